[hdl/rmq_pkg.sv]
package rmq_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam int BEAT_W  = 16;
    localparam int TRACE_W = 18;
    localparam int PAIR_W  = 17;
    localparam int QUO_W   = 17;

    localparam logic [1:0] SEL_W = 2'd0;
    localparam logic [1:0] SEL_X = 2'd1;
    localparam logic [1:0] SEL_Y = 2'd2;
    localparam logic [1:0] SEL_Z = 2'd3;

    typedef struct packed {
        logic signed [BEAT_W-1:0] entry_0;
        logic signed [BEAT_W-1:0] entry_1;
        logic signed [BEAT_W-1:0] entry_2;
        logic signed [BEAT_W-1:0] entry_3;
        logic signed [BEAT_W-1:0] entry_4;
        logic signed [BEAT_W-1:0] entry_5;
        logic signed [BEAT_W-1:0] entry_6;
        logic signed [BEAT_W-1:0] entry_7;
        logic signed [BEAT_W-1:0] entry_8;
    } in_beat_t;

    typedef struct packed {
        logic signed [BEAT_W-1:0] quat_x;
        logic signed [BEAT_W-1:0] quat_y;
        logic signed [BEAT_W-1:0] quat_z;
        logic signed [BEAT_W-1:0] quat_w;
    } out_beat_t;

    // three off-diagonal lanes, in x,y,z,w order with the winner skipped
    typedef struct packed {
        logic [1:0]              sel;
        logic [2:0]              neg;
        logic [2:0][PAIR_W-1:0]  mag;
    } side_t;

    typedef struct packed {
        logic [1:0]        sel;
        logic [2:0]        neg;
        logic [BEAT_W-1:0] big;
    } dside_t;

    // width of s = best + 1.0
    function automatic int sum_w(input int f);
        return (f + 2 > 18) ? f + 2 : 18;
    endfunction

    // root bits for X = s << f
    function automatic int root_w(input int f);
        return (sum_w(f) + f + 1) / 2;
    endfunction

endpackage

[hdl/rmq_front.sv]
module rmq_front import rmq_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  in_beat_t                                in_data,
    output logic                                    out_valid,
    output logic [2*root_w(FRACTION_BITS)-1:0]      out_x,
    output side_t                                   out_side
);

    localparam int SW = sum_w(FRACTION_BITS);
    localparam int RW = root_w(FRACTION_BITS);
    localparam int XW = 2 * RW;

    logic signed [TRACE_W-1:0] t_next [4];
    logic signed [TRACE_W-1:0] t_reg  [4];
    logic signed [PAIR_W-1:0]  p_next [6];
    logic signed [PAIR_W-1:0]  p_reg  [6];
    logic                      v1_reg;

    logic signed [TRACE_W-1:0] e0, e4, e8;
    logic signed [PAIR_W-1:0]  d1, d2, d3, d5, d6, d7;

    always_comb begin
        e0 = TRACE_W'(in_data.entry_0);
        e4 = TRACE_W'(in_data.entry_4);
        e8 = TRACE_W'(in_data.entry_8);
        d1 = PAIR_W'(in_data.entry_1);
        d2 = PAIR_W'(in_data.entry_2);
        d3 = PAIR_W'(in_data.entry_3);
        d5 = PAIR_W'(in_data.entry_5);
        d6 = PAIR_W'(in_data.entry_6);
        d7 = PAIR_W'(in_data.entry_7);
        t_next[0] = e0 + e4 + e8;
        t_next[1] = e0 - e4 - e8;
        t_next[2] = e4 - e0 - e8;
        t_next[3] = e8 - e0 - e4;
        p_next[0] = d5 - d7;
        p_next[1] = d6 - d2;
        p_next[2] = d1 - d3;
        p_next[3] = d1 + d3;
        p_next[4] = d6 + d2;
        p_next[5] = d5 + d7;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= t_next;
            p_reg <= p_next;
        end
    end

    // stage 2: pick the winner, route the pairs, form X
    logic signed [TRACE_W-1:0] best;
    logic [1:0]                sel;
    logic signed [PAIR_W-1:0]  lane [3];
    logic [SW-1:0]             s_sum;
    logic [XW-1:0]             x_next;
    side_t                     side_next;

    always_comb begin
        best = t_reg[0];
        sel  = SEL_W;
        if (t_reg[1] > best) begin
            best = t_reg[1];
            sel  = SEL_X;
        end
        if (t_reg[2] > best) begin
            best = t_reg[2];
            sel  = SEL_Y;
        end
        if (t_reg[3] > best) begin
            best = t_reg[3];
            sel  = SEL_Z;
        end
        unique case (sel)
            SEL_W: begin
                lane[0] = p_reg[0]; lane[1] = p_reg[1]; lane[2] = p_reg[2];
            end
            SEL_X: begin
                lane[0] = p_reg[3]; lane[1] = p_reg[4]; lane[2] = p_reg[0];
            end
            SEL_Y: begin
                lane[0] = p_reg[3]; lane[1] = p_reg[5]; lane[2] = p_reg[1];
            end
            default: begin
                lane[0] = p_reg[4]; lane[1] = p_reg[5]; lane[2] = p_reg[2];
            end
        endcase
        side_next.sel = sel;
        for (int i = 0; i < 3; i++) begin
            side_next.neg[i] = lane[i][PAIR_W-1];
            side_next.mag[i] = lane[i][PAIR_W-1] ? PAIR_W'(-lane[i]) : PAIR_W'(lane[i]);
        end
        // best is never negative: the four traces sum to zero
        s_sum  = SW'(best[TRACE_W-2:0]) + (SW'(1) << FRACTION_BITS);
        x_next = XW'(s_sum) << FRACTION_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_x    <= x_next;
            out_side <= side_next;
        end
    end

endmodule

[hdl/rmq_sqrt.sv]
module rmq_sqrt import rmq_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2*root_w(FRACTION_BITS)-1:0]  in_x,
    input  side_t                               in_side,
    output logic                                out_valid,
    output logic [root_w(FRACTION_BITS)-1:0]    out_root,
    output side_t                               out_side
);

    localparam int RW = root_w(FRACTION_BITS);
    localparam int XW = 2 * RW;

    logic [RW:1]          v_reg;
    logic [RW+1:0]        rem_reg  [RW:1];
    logic [RW-1:0]        root_reg [RW:1];
    logic [XW-1:0]        x_reg    [RW:1];
    side_t                side_reg [RW:1];

    // one root bit per stage, restoring
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          vin;
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [XW-1:0] x_in;
        side_t         side_in;
        logic [RW+3:0] cat, trial;
        logic [RW+1:0] rem_next;
        logic [RW-1:0] root_next;

        if (k == 0) begin : g_first
            assign vin     = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = in_x;
            assign side_in = in_side;
        end else begin : g_rest
            assign vin     = v_reg[k];
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign x_in    = x_reg[k];
            assign side_in = side_reg[k];
        end

        always_comb begin
            cat   = {rem_in, x_in[XW-1-2*k -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (cat >= trial) begin
                rem_next  = (RW+2)'(cat - trial);
                root_next = {root_in[RW-2:0], 1'b1};
            end else begin
                rem_next  = cat[RW+1:0];
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                x_reg[k+1]    <= x_in;
                side_reg[k+1] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

[hdl/rmq_div.sv]
module rmq_div import rmq_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [root_w(FRACTION_BITS)-1:0]  in_root,
    input  side_t                             in_side,
    output logic                              out_valid,
    output logic [2:0][QUO_W-1:0]             out_quo,
    output dside_t                            out_side
);

    localparam int RW = root_w(FRACTION_BITS);
    localparam int DW = RW + 2;
    localparam int NW = FRACTION_BITS + PAIR_W + 1;
    localparam int CW = (NW > DW + QUO_W) ? NW : DW + QUO_W;

    // big = root rounded, den = 4*big, num = mag*2^F + 2*big
    logic [RW:0]            rp1;
    logic [RW-1:0]          big;
    logic [31:0]            big32;
    dside_t                 ds_next;
    logic [2:0][NW-1:0]     num_next;

    always_comb begin
        rp1   = {1'b0, in_root} + (RW+1)'(1);
        big   = rp1[RW:1];
        big32 = 32'(big);
        ds_next.sel = in_side.sel;
        ds_next.neg = in_side.neg;
        ds_next.big = (big32 > 32'd32767) ? BEAT_W'(32767) : big32[BEAT_W-1:0];
        for (int i = 0; i < 3; i++) begin
            num_next[i] = (NW'(in_side.mag[i]) << FRACTION_BITS) + (NW'(big) << 1);
        end
    end

    logic [QUO_W:0]           v_reg;
    logic [2:0][NW-1:0]       rem_reg  [QUO_W:0];
    logic [2:0][QUO_W-1:0]    quo_reg  [QUO_W:0];
    logic [DW-1:0]            den_reg  [QUO_W:0];
    dside_t                   ds_reg   [QUO_W:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_next;
            quo_reg[0] <= '0;
            den_reg[0] <= {big, 2'b00};
            ds_reg[0]  <= ds_next;
        end
    end

    // one quotient bit per stage for each of the three lanes
    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int SH = QUO_W - 1 - j;
        logic [CW-1:0]          dsh;
        logic [2:0][NW-1:0]     rem_next;
        logic [2:0][QUO_W-1:0]  quo_next;

        always_comb begin
            dsh = CW'(den_reg[j]) << SH;
            for (int i = 0; i < 3; i++) begin
                if (CW'(rem_reg[j][i]) >= dsh) begin
                    rem_next[i] = NW'(CW'(rem_reg[j][i]) - dsh);
                    quo_next[i] = {quo_reg[j][i][QUO_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = rem_reg[j][i];
                    quo_next[i] = {quo_reg[j][i][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= rem_next;
                quo_reg[j+1] <= quo_next;
                den_reg[j+1] <= den_reg[j];
                ds_reg[j+1]  <= ds_reg[j];
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_side  = ds_reg[QUO_W];

endmodule

[hdl/rotation_matrix_to_quaternion.sv]
// channel  | ports                       | beat
// ---------+-----------------------------+----------------------------------
// input    | s_valid, s_ready, s_data    | nine Q1.14 matrix entries
// result   | m_valid, m_ready, m_data    | quaternion x, y, z, w in Q1.14
//
// One beat in and one beat out per cycle when the result side keeps m_ready high.
// The pipeline has two front stages, one stage per root bit in the square root,
// a rounding stage, 17 divider stages and one output register.
// A stall on m_ready freezes the whole pipeline; nothing is dropped or repeated.
// aresetn is synchronous and clears only the valid bits.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int RW = root_w(FRACTION_BITS);
    localparam int BIG_MIN = (FRACTION_BITS - 1 > 14) ? 32767 : (1 << (FRACTION_BITS - 1));

    logic                 en;
    logic                 m_valid_reg;
    out_beat_t            m_data_reg;

    logic                 f_valid;
    logic [2*RW-1:0]      f_x;
    side_t                f_side;
    logic                 r_valid;
    logic [RW-1:0]        r_root;
    side_t                r_side;
    logic                 d_valid;
    logic [2:0][QUO_W-1:0] d_quo;
    dside_t               d_side;

    // advance everything unless a finished beat is waiting and m_ready is low
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    rmq_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (f_valid),
        .out_x     (f_x),
        .out_side  (f_side)
    );

    rmq_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_x      (f_x),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    rmq_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_side   (r_side),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    // apply sign and saturate each lane, then place the winner
    logic signed [BEAT_W-1:0] lane [3];
    out_beat_t                m_data_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (d_side.neg[i]) begin
                if (d_quo[i] > QUO_W'(32768)) begin
                    lane[i] = -16'sd32768;
                end else begin
                    lane[i] = BEAT_W'(-d_quo[i]);
                end
            end else begin
                if (d_quo[i] > QUO_W'(32767)) begin
                    lane[i] = 16'sd32767;
                end else begin
                    lane[i] = d_quo[i][BEAT_W-1:0];
                end
            end
        end
        unique case (d_side.sel)
            SEL_W: begin
                m_data_next.quat_x = lane[0];
                m_data_next.quat_y = lane[1];
                m_data_next.quat_z = lane[2];
                m_data_next.quat_w = d_side.big;
            end
            SEL_X: begin
                m_data_next.quat_x = d_side.big;
                m_data_next.quat_y = lane[0];
                m_data_next.quat_z = lane[1];
                m_data_next.quat_w = lane[2];
            end
            SEL_Y: begin
                m_data_next.quat_x = lane[0];
                m_data_next.quat_y = d_side.big;
                m_data_next.quat_z = lane[1];
                m_data_next.quat_w = lane[2];
            end
            default: begin
                m_data_next.quat_x = lane[0];
                m_data_next.quat_y = lane[1];
                m_data_next.quat_z = d_side.big;
                m_data_next.quat_w = lane[2];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    a_big_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.quat_x >= BIG_MIN) || (m_data.quat_y >= BIG_MIN) ||
                    (m_data.quat_z >= BIG_MIN) || (m_data.quat_w >= BIG_MIN))
        else $error("no component carries the root term");
`endif

endmodule

[test/rotation_matrix_to_quaternion_tb.sv]
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB          = 14;
    localparam int N_RANDOM    = 1200;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 80;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    out_beat_t quat_fifo[$];
    int        mismatch_cnt;
    int        idle_cnt;
    bit        quiet_run;
    bit        timed_out;

    rotation_matrix_to_quaternion dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint floor_root(input longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // pair * 2^F / (4*root), nearest, halves away from zero
    function automatic logic signed [15:0] div_by_root(input longint p, input longint root);
        longint m;
        longint den;
        longint q;
        m   = (p < 0) ? -p : p;
        den = root * 4;
        q   = ((m <<< FB) + den / 2) / den;
        return clamp16((p < 0) ? -q : q);
    endfunction

    function automatic out_beat_t matrix_to_quat(input in_beat_t a);
        longint    d[9];
        longint    tr[4];
        longint    best;
        longint    root;
        int        pick;
        out_beat_t q;
        d[0] = a.entry_0; d[1] = a.entry_1; d[2] = a.entry_2;
        d[3] = a.entry_3; d[4] = a.entry_4; d[5] = a.entry_5;
        d[6] = a.entry_6; d[7] = a.entry_7; d[8] = a.entry_8;
        tr[0] = d[0] + d[4] + d[8];
        tr[1] = d[0] - d[4] - d[8];
        tr[2] = d[4] - d[0] - d[8];
        tr[3] = d[8] - d[0] - d[4];
        pick = SEL_W;
        best = tr[0];
        for (int i = 1; i < 4; i++) begin
            if (tr[i] > best) begin
                best = tr[i];
                pick = i;
            end
        end
        root = (floor_root((best + (64'sd1 <<< FB)) <<< FB) + 1) >>> 1;
        if (root == 0) root = 1;
        case (pick)
            SEL_W: begin
                q.quat_x = div_by_root(d[5] - d[7], root);
                q.quat_y = div_by_root(d[6] - d[2], root);
                q.quat_z = div_by_root(d[1] - d[3], root);
                q.quat_w = clamp16(root);
            end
            SEL_X: begin
                q.quat_x = clamp16(root);
                q.quat_y = div_by_root(d[1] + d[3], root);
                q.quat_z = div_by_root(d[6] + d[2], root);
                q.quat_w = div_by_root(d[5] - d[7], root);
            end
            SEL_Y: begin
                q.quat_x = div_by_root(d[1] + d[3], root);
                q.quat_y = clamp16(root);
                q.quat_z = div_by_root(d[5] + d[7], root);
                q.quat_w = div_by_root(d[6] - d[2], root);
            end
            default: begin
                q.quat_x = div_by_root(d[6] + d[2], root);
                q.quat_y = div_by_root(d[5] + d[7], root);
                q.quat_z = clamp16(root);
                q.quat_w = div_by_root(d[1] - d[3], root);
            end
        endcase
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    typedef struct {
        in_beat_t  mat;
        bit        typed;
        out_beat_t quat;
    } vec_t;

    localparam logic signed [15:0] ONE  = 16'sd16384;
    localparam logic signed [15:0] MONE = -16'sd16384;
    localparam logic signed [15:0] HALF = 16'sd8192;
    localparam logic signed [15:0] MAXV = 16'sh7fff;
    localparam logic signed [15:0] MINV = 16'sh8000;

    vec_t      vectors[$];
    in_beat_t  pending[$];

    function automatic in_beat_t mk(input logic signed [15:0] e0, e1, e2, e3, e4, e5,
                                    e6, e7, e8);
        in_beat_t m;
        m = '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
        return m;
    endfunction

    function automatic out_beat_t qk(input logic signed [15:0] x, y, z, w);
        out_beat_t q;
        q = '{x, y, z, w};
        return q;
    endfunction

    task automatic add_vec(input in_beat_t m, input bit typed, input out_beat_t q);
        vec_t v;
        v.mat = m; v.typed = typed; v.quat = q;
        vectors.push_back(v);
    endtask

    function automatic in_beat_t random_matrix();
        in_beat_t m;
        logic signed [15:0] e[9];
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            if (mode == 0)
                e[i] = 16'($urandom);
            else if (mode == 1)
                e[i] = ($urandom_range(0, 1)) ? ONE : MONE;
            else
                e[i] = 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
        end
        m = mk(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
        return m;
    endfunction

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        mismatch_cnt = 0;

        // identity and 180 degree turns about each axis
        add_vec(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, qk(0, 0, 0, ONE));
        add_vec(mk(ONE, 0, 0, 0, MONE, 0, 0, 0, MONE), 1, qk(ONE, 0, 0, 0));
        add_vec(mk(MONE, 0, 0, 0, ONE, 0, 0, 0, MONE), 1, qk(0, ONE, 0, 0));
        add_vec(mk(MONE, 0, 0, 0, MONE, 0, 0, 0, ONE), 1, qk(0, 0, ONE, 0));
        // all zero: tie across every combination, w kept
        add_vec(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, qk(0, 0, 0, HALF));
        // ties between x and y, and y and z
        add_vec(mk(0, 0, 0, 0, 0, 0, 0, 0, MONE), 0, '0);
        add_vec(mk(MONE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        // 90 degree turns
        add_vec(mk(0, ONE, 0, MONE, 0, 0, 0, 0, ONE), 0, '0);
        add_vec(mk(ONE, 0, 0, 0, 0, ONE, 0, MONE, 0), 0, '0);
        add_vec(mk(0, 0, MONE, 0, ONE, 0, ONE, 0, 0), 0, '0);
        // field extremes and saturating off-diagonals
        add_vec(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0, '0);
        add_vec(mk(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV), 0, '0);
        add_vec(mk(0, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 0), 0, '0);
        add_vec(mk(MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV), 0, '0);
        add_vec(mk(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                   16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555), 0, '0);
        add_vec(mk(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                   16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa), 0, '0);
        add_vec(mk(-1, 1, -1, 1, -1, 1, -1, 1, -1), 0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (vectors[i]) pending.push_back(vectors[i].mat);
        for (int i = 0; i < N_RANDOM; i++) pending.push_back(random_matrix());

        while (pending.size() > 0) begin
            @(posedge aclk);
            if (!s_valid || s_ready) begin
                if (s_valid && s_ready) begin
                    // accepted beat already predicted; pick the next
                end
                if (!quiet_run && $urandom_range(0, 99) < 11) begin
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= pending.pop_front();
                end
            end
        end
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        s_valid <= 1'b0;
    end

    // predict at acceptance
    int vec_idx = 0;
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (vec_idx < vectors.size() && vectors[vec_idx].typed)
                quat_fifo.push_back(vectors[vec_idx].quat);
            else
                quat_fifo.push_back(matrix_to_quat(s_data));
            vec_idx++;
        end
    end

    // result side: random stall with a long stall-free stretch
    initial begin
        m_ready = 1'b0;
        quiet_run = 1'b0;
        forever begin
            @(posedge aclk);
            if (vec_idx > 400 && vec_idx < 700) quiet_run <= 1'b1;
            else quiet_run <= 1'b0;
            m_ready <= quiet_run || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (quat_fifo.size() == 0) begin
                report_mismatch("unexpected beat, quat_x", m_data.quat_x, 0);
            end else begin
                want = quat_fifo.pop_front();
                if (m_data.quat_x !== want.quat_x)
                    report_mismatch("quat_x", m_data.quat_x, want.quat_x);
                if (m_data.quat_y !== want.quat_y)
                    report_mismatch("quat_y", m_data.quat_y, want.quat_y);
                if (m_data.quat_z !== want.quat_z)
                    report_mismatch("quat_z", m_data.quat_z, want.quat_z);
                if (m_data.quat_w !== want.quat_w)
                    report_mismatch("quat_w", m_data.quat_w, want.quat_w);
            end
        end
    end

    // watchdog and end of run
    initial begin
        idle_cnt  = 0;
        timed_out = 0;
        wait (aresetn);
        while (!(vec_idx == vectors.size() + N_RANDOM && quat_fifo.size() == 0)
               && !timed_out) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) timed_out = 1;
        end
        if (!timed_out) repeat (DRAIN_WAIT) @(posedge aclk);
        if (!timed_out && mismatch_cnt == 0)
            $display("rotation_matrix_to_quaternion test passed");
        else
            $display("rotation_matrix_to_quaternion test failed");
        $finish;
    end

endmodule

[files.f]
hdl/rmq_pkg.sv
hdl/rmq_front.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_tb.sv
